// ===== rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants of the periodic-extract minimum priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int unsigned CNT_W = 4;
	localparam logic [CNT_W-1:0] INTERVAL_RESET = 4'd3;

	// Control flags that travel alongside one read-data word of the scan.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} scan_ctl_t;

endpackage

// ===== rtl/mpq_ram.sv =====
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mpq_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mpq_min_scan.sv =====
// ----------------------------------------------------------------------------
// mpq_min_scan
// Running minimum over the words read back from the entry store, one word
// a cycle, keeping the index of the first smallest value and the last word.
// ----------------------------------------------------------------------------
module mpq_min_scan
	import mpq_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 16,
	parameter int unsigned IDX_W       = 6
) (
	input  logic                   clk,
	input  scan_ctl_t              ctl,
	input  logic [IDX_W-1:0]       idx,
	input  logic [VALUE_WIDTH-1:0] rd_data,
	output logic [VALUE_WIDTH-1:0] best_val,
	output logic [IDX_W-1:0]       best_idx,
	output logic [VALUE_WIDTH-1:0] last_val
);

	logic [VALUE_WIDTH-1:0] best_val_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [VALUE_WIDTH-1:0] last_val_q;

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			// A strict compare keeps the earliest of equal minima.
			if (ctl.first || (rd_data < best_val_q)) begin
				best_val_q <= rd_data;
				best_idx_q <= idx;
			end
			if (ctl.last) begin
				last_val_q <= rd_data;
			end
		end
	end

	assign best_val = best_val_q;
	assign best_idx = best_idx_q;
	assign last_val = last_val_q;

endmodule

// ===== rtl/min_priority_queue_periodic_extract.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_periodic_extract
// Bounded minimum priority queue that removes its smallest value on every
// Nth add, with the values held in a single-port-read synchronous RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and produces exactly
// one result, shown for a single cycle with done high; the receiver cannot
// stall it, so it must take the result in that cycle. An item that does not
// trigger a removal leaves busy low, so items may follow back to back. An
// item that triggers a removal holds busy high through a linear scan of the
// store over the n values held after the add, one RAM read a cycle, then a
// drain state that finishes the reads and a fix state that writes the last
// entry into the hole; its result is shown with done as busy falls. A write
// to the interval register is taken at any clock edge with cfg_wr_en high.
// ----------------------------------------------------------------------------
module min_priority_queue_periodic_extract
	import mpq_pkg::*;
#(
	parameter int unsigned DEPTH       = 64,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [CNT_W-1:0]             cfg_wr_data,
	input  logic                         start,
	input  logic [VALUE_WIDTH-1:0]       priority_req,
	output logic                         busy,
	output logic                         done,
	output logic                         admitted,
	output logic [VALUE_WIDTH-1:0]       admitted_priority,
	output logic                         accepted,
	output logic [$clog2(DEPTH+1)-1:0]   waiting
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned OCC_W = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIX   = 2'd3;

	logic [1:0]             state_q;
	logic [OCC_W-1:0]       occ_q;
	logic [OCC_W-1:0]       n_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       interval_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic                   acc_q;

	logic                   done_q;
	logic                   admitted_q;
	logic [VALUE_WIDTH-1:0] admitted_priority_q;
	logic                   accepted_q;
	logic [OCC_W-1:0]       waiting_q;

	scan_ctl_t              ctl_s1;
	logic [IDX_W-1:0]       idx_s1;

	logic                   take;
	logic                   full;
	logic [OCC_W-1:0]       occ_ins;
	logic [CNT_W-1:0]       cnt_next;
	logic                   fire;
	logic                   rd_last;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	logic [VALUE_WIDTH-1:0] best_val;
	logic [IDX_W-1:0]       best_idx;
	logic [VALUE_WIDTH-1:0] last_val;

	assign take     = start && (state_q == ST_IDLE);
	assign full     = (occ_q == OCC_W'(DEPTH));
	assign occ_ins  = full ? occ_q : (occ_q + OCC_W'(1));
	assign cnt_next = cnt_q + CNT_W'(1);
	assign fire     = (cnt_next >= interval_q);
	assign rd_last  = (OCC_W'(rd_idx_q) == (n_q - OCC_W'(1)));

	// The store is written either by an add or by moving the last entry
	// into the hole left by the removed minimum; the two never coincide.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = occ_q[IDX_W-1:0];
		ram_wdata = priority_req;
		if (take && !full) begin
			ram_we = 1'b1;
		end else if (state_q == ST_FIX) begin
			ram_we    = 1'b1;
			ram_waddr = best_idx;
			ram_wdata = last_val;
		end
	end

	assign ram_re = (state_q == ST_SCAN);

	mpq_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	mpq_min_scan #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.IDX_W       (IDX_W)
	) u_scan (
		.clk      (clk),
		.ctl      (ctl_s1),
		.idx      (idx_s1),
		.rd_data  (ram_rdata),
		.best_val (best_val),
		.best_idx (best_idx),
		.last_val (last_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_wr_en) begin
			interval_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ST_IDLE;
			occ_q               <= '0;
			n_q                 <= '0;
			cnt_q               <= '0;
			acc_q               <= 1'b0;
			done_q              <= 1'b0;
			admitted_q          <= 1'b0;
			admitted_priority_q <= '0;
			accepted_q          <= 1'b0;
			waiting_q           <= '0;
			ctl_s1              <= '0;
			idx_s1              <= '0;
			rd_idx_q            <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ctl_s1 <= '0;
					if (take) begin
						occ_q <= occ_ins;
						acc_q <= !full;
						if (fire && (occ_ins != '0)) begin
							cnt_q    <= '0;
							n_q      <= occ_ins;
							rd_idx_q <= '0;
							done_q   <= 1'b0;
							state_q  <= ST_SCAN;
						end else begin
							cnt_q               <= fire ? '0 : cnt_next;
							done_q              <= 1'b1;
							admitted_q          <= 1'b0;
							admitted_priority_q <= '0;
							accepted_q          <= !full;
							waiting_q           <= occ_ins;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					done_q       <= 1'b0;
					ctl_s1.valid <= 1'b1;
					ctl_s1.first <= (rd_idx_q == '0);
					ctl_s1.last  <= rd_last;
					idx_s1       <= rd_idx_q;
					rd_idx_q     <= rd_idx_q + IDX_W'(1);
					if (rd_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					done_q  <= 1'b0;
					ctl_s1  <= '0;
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					ctl_s1              <= '0;
					occ_q               <= n_q - OCC_W'(1);
					done_q              <= 1'b1;
					admitted_q          <= 1'b1;
					admitted_priority_q <= best_val;
					accepted_q          <= acc_q;
					waiting_q           <= n_q - OCC_W'(1);
					state_q             <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					ctl_s1  <= '0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign done              = done_q;
	assign admitted          = admitted_q;
	assign admitted_priority = admitted_priority_q;
	assign accepted          = accepted_q;
	assign waiting           = waiting_q;

endmodule
